@@ src/erol_pkg.sv @@
// shared types, constants and codes for the entry ring offset lookup block
`default_nettype none

package erol_pkg;

  // default sizing handed to the top level parameters
  localparam int unsigned RING_SLOTS_DEF  = 16;
  localparam int unsigned LENGTH_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned IN_LEN_W   = 16;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned OUT_LEN_W  = 16;

  // opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DELIVER
  } state_e;

  // source of the ring read address
  typedef enum logic [1:0] {
    RD_WRITE_SLOT,
    RD_IDX,
    RD_IDX_NEXT
  } rd_src_e;

  // one result item
  typedef struct packed {
    logic                  evicted_valid;
    logic [ADDR_W-1:0]     evicted_address;
    logic                  found;
    logic [SLOT_OUT_W-1:0] found_slot;
    logic [ADDR_W-1:0]     found_address;
    logic [OUT_LEN_W-1:0]  found_length;
    logic [OUT_LEN_W-1:0]  byte_within;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    rd_src_e rd_src;
    logic    add_commit;
    logic    find_empty;
    logic    find_step;
    logic    load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_add;
    logic cnt_zero;
    logic hit;
    logic last_rec;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ src/erol_in_if.sv @@
// input channel interface: valid, ready and the request item fields
`default_nettype none

interface erol_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [erol_pkg::ADDR_W-1:0]     record_address;
  logic [erol_pkg::IN_LEN_W-1:0]   record_length;
  logic [erol_pkg::OFFSET_W-1:0]   text_offset;

  modport source (output valid, opcode, record_address, record_length, text_offset,
                  input ready);
  modport sink   (input valid, opcode, record_address, record_length, text_offset,
                  output ready);
endinterface

`default_nettype wire

@@ src/erol_out_if.sv @@
// output channel interface: valid, ready and the result item fields
`default_nettype none

interface erol_out_if;
  logic                              valid;
  logic                              ready;
  logic                              evicted_valid;
  logic [erol_pkg::ADDR_W-1:0]       evicted_address;
  logic                              found;
  logic [erol_pkg::SLOT_OUT_W-1:0]   found_slot;
  logic [erol_pkg::ADDR_W-1:0]       found_address;
  logic [erol_pkg::OUT_LEN_W-1:0]    found_length;
  logic [erol_pkg::OUT_LEN_W-1:0]    byte_within;

  modport source (output valid, evicted_valid, evicted_address, found, found_slot,
                  found_address, found_length, byte_within,
                  input ready);
  modport sink   (input valid, evicted_valid, evicted_address, found, found_slot,
                  found_address, found_length, byte_within,
                  output ready);
endinterface

`default_nettype wire

@@ src/erol_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none

module erol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ src/erol_ctrl.sv @@
// controller state machine sequencing adds, ring walks and result delivery
`default_nettype none

module erol_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire erol_pkg::ctrl_sts_t  sts_i,
  output erol_pkg::ctrl_cmd_t       cmd_o
);

  erol_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erol_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.rd_src      = erol_pkg::RD_IDX;
    case (state_q)
      erol_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = erol_pkg::ST_FIND_RD;
        end
      end
      erol_pkg::ST_FIND_RD: begin
        // the latched opcode picks the path
        if (sts_i.is_add) begin
          cmd_o.rd_src = erol_pkg::RD_WRITE_SLOT;
          state_d      = erol_pkg::ST_ADD_WR;
        end else if (sts_i.cnt_zero) begin
          cmd_o.find_empty = 1'b1;
          state_d          = erol_pkg::ST_DELIVER;
        end else begin
          cmd_o.rd_src = erol_pkg::RD_IDX;
          state_d      = erol_pkg::ST_FIND_CHK;
        end
      end
      erol_pkg::ST_ADD_RD: begin
        cmd_o.rd_src = erol_pkg::RD_WRITE_SLOT;
        state_d      = erol_pkg::ST_ADD_WR;
      end
      erol_pkg::ST_ADD_WR: begin
        cmd_o.add_commit = 1'b1;
        state_d          = erol_pkg::ST_DELIVER;
      end
      erol_pkg::ST_FIND_CHK: begin
        // check one record while the next one is read
        cmd_o.find_step = 1'b1;
        cmd_o.rd_src    = erol_pkg::RD_IDX_NEXT;
        if (sts_i.hit || sts_i.last_rec) begin
          state_d = erol_pkg::ST_DELIVER;
        end
      end
      erol_pkg::ST_DELIVER: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = erol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = erol_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/erol_datapath.sv @@
// datapath: record ring, slot pointers, walk registers and result registers
`default_nettype none

module erol_datapath #(
  parameter int unsigned RING_SLOTS  = erol_pkg::RING_SLOTS_DEF,
  parameter int unsigned LENGTH_BITS = erol_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire erol_pkg::ctrl_cmd_t           cmd_i,
  output erol_pkg::ctrl_sts_t                sts_o,
  input  wire logic                          opcode_i,
  input  wire logic [erol_pkg::ADDR_W-1:0]   record_address_i,
  input  wire logic [erol_pkg::IN_LEN_W-1:0] record_length_i,
  input  wire logic [erol_pkg::OFFSET_W-1:0] text_offset_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output erol_pkg::result_t                  out_res_o
);

  localparam int unsigned SLOT_W     = $clog2(RING_SLOTS);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned REC_W      = erol_pkg::ADDR_W + LENGTH_BITS;
  localparam int unsigned LEN_PAD_W  = (LENGTH_BITS > erol_pkg::IN_LEN_W) ?
                                       LENGTH_BITS : erol_pkg::IN_LEN_W;
  localparam int unsigned SUM_W      = ((LENGTH_BITS > erol_pkg::OFFSET_W) ?
                                       LENGTH_BITS : erol_pkg::OFFSET_W) + 1;
  localparam int unsigned SLOT_PAD_W = (SLOT_W > erol_pkg::SLOT_OUT_W) ?
                                       SLOT_W : erol_pkg::SLOT_OUT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_SLOTS);

  // latched request
  logic                          op_q;
  logic [erol_pkg::ADDR_W-1:0]   rec_addr_q;
  logic [LENGTH_BITS-1:0]        rec_len_q;
  logic [erol_pkg::OFFSET_W-1:0] off_q;

  // ring pointers
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic              full_q, full_d;

  // walk registers
  logic [SLOT_W-1:0]             idx_q, idx_d;
  logic [erol_pkg::OFFSET_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;

  // result and output registers
  erol_pkg::result_t res_q, res_d;
  erol_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;

  // ram signals
  logic [SLOT_W-1:0] ram_rd_addr;
  logic [REC_W-1:0]  ram_rd_data;
  logic [REC_W-1:0]  ram_wr_data;

  // derived values
  logic [LEN_PAD_W-1:0]          len_in_pad;
  logic [SLOT_W-1:0]             wr_slot_next, rd_slot_next, idx_next;
  logic [CNT_W-1:0]              fill_cnt;
  logic [erol_pkg::ADDR_W-1:0]   cur_addr;
  logic [LENGTH_BITS-1:0]        cur_len;
  logic [SUM_W-1:0]              sum_plus_len;
  logic [SUM_W-1:0]              byte_off;
  logic [LEN_PAD_W-1:0]          cur_len_pad;
  logic [SLOT_PAD_W-1:0]         idx_pad;
  logic                          hit;

  // input length kept to the stored width
  assign len_in_pad = LEN_PAD_W'(record_length_i);

  // slot increments with wrap
  assign wr_slot_next = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
  assign rd_slot_next = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
  assign idx_next     = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

  // number of stored records
  always_comb begin
    if (full_q) begin
      fill_cnt = FULL_CNT;
    end else if (wr_slot_q >= rd_slot_q) begin
      fill_cnt = CNT_W'(wr_slot_q) - CNT_W'(rd_slot_q);
    end else begin
      fill_cnt = CNT_W'(wr_slot_q) + FULL_CNT - CNT_W'(rd_slot_q);
    end
  end

  // ring read address
  always_comb begin
    case (cmd_i.rd_src)
      erol_pkg::RD_WRITE_SLOT: ram_rd_addr = wr_slot_q;
      erol_pkg::RD_IDX:        ram_rd_addr = idx_q;
      erol_pkg::RD_IDX_NEXT:   ram_rd_addr = idx_next;
      default:                 ram_rd_addr = idx_q;
    endcase
  end

  assign ram_wr_data = {rec_addr_q, rec_len_q};

  erol_ram #(
    .WIDTH (REC_W),
    .DEPTH (RING_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.add_commit),
    .wr_addr_i (wr_slot_q),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // containment check of the record being walked
  assign cur_addr     = ram_rd_data[REC_W-1:LENGTH_BITS];
  assign cur_len      = ram_rd_data[LENGTH_BITS-1:0];
  assign sum_plus_len = SUM_W'(sum_q) + SUM_W'(cur_len);
  assign hit          = SUM_W'(off_q) < sum_plus_len;
  assign byte_off     = SUM_W'(off_q) - SUM_W'(sum_q);
  assign cur_len_pad  = LEN_PAD_W'(cur_len);
  assign idx_pad      = SLOT_PAD_W'(idx_q);

  // request latch, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      rec_addr_q <= record_address_i;
      rec_len_q  <= len_in_pad[LENGTH_BITS-1:0];
      off_q      <= text_offset_i;
    end
  end

  // pointer and walk next state
  always_comb begin
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    full_d    = full_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    if (cmd_i.accept) begin
      idx_d = rd_slot_q;
      sum_d = '0;
      cnt_d = fill_cnt;
    end
    if (cmd_i.add_commit) begin
      wr_slot_d = wr_slot_next;
      if (full_q) begin
        rd_slot_d = rd_slot_next;
      end
      full_d = full_q | (wr_slot_next == rd_slot_q);
    end
    if (cmd_i.find_step && !hit) begin
      idx_d = idx_next;
      sum_d = sum_plus_len[erol_pkg::OFFSET_W-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  // result next state
  always_comb begin
    res_d = res_q;
    if (cmd_i.add_commit) begin
      res_d                 = '0;
      res_d.evicted_valid   = full_q;
      res_d.evicted_address = full_q ? cur_addr : '0;
    end
    if (cmd_i.find_empty) begin
      res_d = '0;
    end
    if (cmd_i.find_step) begin
      if (hit) begin
        res_d               = '0;
        res_d.found         = 1'b1;
        res_d.found_slot    = idx_pad[erol_pkg::SLOT_OUT_W-1:0];
        res_d.found_address = cur_addr;
        res_d.found_length  = cur_len_pad[erol_pkg::OUT_LEN_W-1:0];
        res_d.byte_within   = byte_off[erol_pkg::OUT_LEN_W-1:0];
      end else if (cnt_q == CNT_W'(1)) begin
        res_d = '0;
      end
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sum_q <= sum_d;
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  // status to the controller
  assign sts_o.is_add   = (op_q == erol_pkg::OP_ADD);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.hit      = hit;
  assign sts_o.last_rec = (cnt_q == CNT_W'(1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

@@ src/entry_ring_offset_lookup_unit.sv @@
// top level of the entry ring offset lookup block
//
// A ring of RING_SLOTS write records (address, length) held in one ram.
// Input channel in_i carries one request item: opcode add stores a record at
// the write slot, overwriting the oldest record when the ring is full and
// reporting its address; opcode find maps a character offset into the
// concatenation of the stored records, oldest first, to a slot, its address
// and length and the byte within it, or reports not found.
// Output channel out_o returns exactly one result item per request.
// An add reads the write slot, then writes the record and sets its result; a
// find walks the stored records, oldest first, at most RING_SLOTS of them.
// The walk checks one stored record per cycle, paced by the ram read port.
// Throughput: one item at a time; in_i.ready is high only while idle, and the
// next item is taken while the previous result still waits in the output
// register. When out_o stalls with a result held and a second one finished,
// the block waits until the output register frees.
// Reset empties the ring (pointers and full flag cleared) and drops any
// pending result; record storage is not cleared and needs no sweep.
`default_nettype none

module entry_ring_offset_lookup_unit #(
  parameter int unsigned RING_SLOTS  = erol_pkg::RING_SLOTS_DEF,
  parameter int unsigned LENGTH_BITS = erol_pkg::LENGTH_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  erol_in_if.sink     in_i,
  erol_out_if.source  out_o
);

  erol_pkg::ctrl_cmd_t cmd;
  erol_pkg::ctrl_sts_t sts;
  erol_pkg::result_t   res;
  logic                out_valid;

  // controller
  erol_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  erol_datapath #(
    .RING_SLOTS  (RING_SLOTS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (in_i.opcode),
    .record_address_i (in_i.record_address),
    .record_length_i  (in_i.record_length),
    .text_offset_i    (in_i.text_offset),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_valid),
    .out_res_o        (res)
  );

  // result item onto the output channel
  assign out_o.valid           = out_valid;
  assign out_o.evicted_valid   = res.evicted_valid;
  assign out_o.evicted_address = res.evicted_address;
  assign out_o.found           = res.found;
  assign out_o.found_slot      = res.found_slot;
  assign out_o.found_address   = res.found_address;
  assign out_o.found_length    = res.found_length;
  assign out_o.byte_within     = res.byte_within;

endmodule

`default_nettype wire
